// ----- sv/deq_pkg.sv -----
// Shared types and codes for the double-ended queue core.
// Holds request codes, status codes, stream widths and the control structs.
// No dependencies.
`default_nettype none

package deq_pkg;

	// Request codes carried in the input tuser
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [2:0] REQ_POP_BACK   = 3'd2;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
	localparam logic [2:0] REQ_READ_POS   = 3'd4;

	// Status codes carried in the output tuser
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_RANGE = 2'd3;

	// Field widths of the stream words
	localparam int REQ_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 5;
	localparam int STAT_W   = 2;
	localparam int LEN_W    = 5;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	// Controller to datapath commands
	typedef struct packed {
		logic exec;   // run the accepted request against the pointers and store
		logic load;   // move the finished result into the output register
	} deq_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_valid;  // output register holds a word not yet taken
	} deq_stat_t;

endpackage

`default_nettype wire

// ----- sv/deq_ctrl.sv -----
// Controller for the double-ended queue core.
// Two-state sequencer: accept a request, then deliver its result.
// Depends on deq_pkg.
`default_nettype none

module deq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic               m_tready,
	input  wire deq_pkg::deq_stat_t stat,
	output deq_pkg::deq_cmd_t       cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RESP = 1'b1;

	logic state_q;
	logic state_d;

	// Decode commands and next state
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.exec = 1'b1;
					state_d  = S_RESP;
				end
			end
			S_RESP: begin
				// load once the output register is free or being drained
				if (!stat.out_valid || m_tready) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/deq_dp.sv -----
// Datapath for the double-ended queue core.
// Holds head/tail pointers, count, the word store and the output register.
// Depends on deq_pkg.
`default_nettype none

module deq_dp #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire deq_pkg::deq_cmd_t             cmd,
	output deq_pkg::deq_stat_t                 stat,
	input  wire logic [deq_pkg::REQ_W-1:0]     req_type,
	input  wire logic [deq_pkg::VALUE_W-1:0]   push_value,
	input  wire logic [deq_pkg::POS_W-1:0]     position,
	input  wire logic                          m_tready,
	output logic [deq_pkg::VALUE_W-1:0]        read_value,
	output logic [deq_pkg::STAT_W-1:0]         status,
	output logic [deq_pkg::LEN_W-1:0]          length,
	output logic                               out_valid
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > 5) ? CW + 1 : 6;
	localparam int VW = (WORD_WIDTH > deq_pkg::VALUE_W) ? WORD_WIDTH : deq_pkg::VALUE_W;
	localparam int LW = (CW > deq_pkg::LEN_W) ? CW : deq_pkg::LEN_W;

	logic [AW-1:0]         head_q;
	logic [AW-1:0]         tail_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         head_d;
	logic [AW-1:0]         tail_d;
	logic [CW-1:0]         count_d;

	logic [WORD_WIDTH-1:0] mem [DEPTH];
	logic [WORD_WIDTH-1:0] rd_data_q;

	logic                  wr_en;
	logic                  rd_en;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr;
	logic [WORD_WIDTH-1:0] wr_data;
	logic [VW-1:0]         push_w;

	logic [1:0]            stat_d;
	logic                  hit_d;
	logic [1:0]            pend_stat_q;
	logic                  pend_hit_q;

	logic                  is_full;
	logic                  is_empty;
	logic                  pos_neg;
	logic [5:0]            pos_mag;
	logic [XW-1:0]         mag_x;
	logic [XW-1:0]         cnt_x;
	logic [XW-1:0]         offset_x;
	logic                  in_range;
	logic [AW:0]           pos_sum;
	logic [AW-1:0]         pos_addr;

	logic [deq_pkg::VALUE_W-1:0] out_value_q;
	logic [1:0]                  out_stat_q;
	logic [deq_pkg::LEN_W-1:0]   out_len_q;
	logic                        out_valid_q;
	logic [VW-1:0]               rd_w;
	logic [LW-1:0]               cnt_l;

	function automatic logic [AW-1:0] step_up(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] step_down(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
	endfunction

	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);

	// Keep the low WORD_WIDTH bits of the pushed word
	assign push_w  = VW'(push_value);
	assign wr_data = push_w[WORD_WIDTH-1:0];

	// Resolve the read position against the count and head pointer
	always_comb begin
		pos_neg  = position[deq_pkg::POS_W-1];
		pos_mag  = pos_neg ? 6'(-$signed({position[deq_pkg::POS_W-1], position}))
		                   : {1'b0, position};
		mag_x    = XW'(pos_mag);
		cnt_x    = XW'(count_q);
		in_range = pos_neg ? (cnt_x >= mag_x) : (mag_x < cnt_x);
		offset_x = pos_neg ? (cnt_x - mag_x) : mag_x;
		pos_sum  = {1'b0, head_q} + {1'b0, offset_x[AW-1:0]};
		pos_addr = (pos_sum >= (AW+1)'(DEPTH)) ? AW'(pos_sum - (AW+1)'(DEPTH))
		                                       : pos_sum[AW-1:0];
	end

	// Decode the request into store accesses and pointer updates
	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		wr_addr = tail_q;
		rd_addr = head_q;
		stat_d  = deq_pkg::STAT_OK;
		hit_d   = 1'b0;
		unique case (req_type)
			deq_pkg::REQ_PUSH_BACK: begin
				if (is_full) begin
					stat_d = deq_pkg::STAT_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = tail_q;
					tail_d  = step_up(tail_q);
					count_d = count_q + CW'(1);
				end
			end
			deq_pkg::REQ_PUSH_FRONT: begin
				if (is_full) begin
					stat_d = deq_pkg::STAT_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = step_down(head_q);
					head_d  = step_down(head_q);
					count_d = count_q + CW'(1);
				end
			end
			deq_pkg::REQ_POP_BACK: begin
				if (is_empty) begin
					stat_d = deq_pkg::STAT_EMPTY;
				end else begin
					rd_en   = 1'b1;
					hit_d   = 1'b1;
					rd_addr = step_down(tail_q);
					tail_d  = step_down(tail_q);
					count_d = count_q - CW'(1);
				end
			end
			deq_pkg::REQ_POP_FRONT: begin
				if (is_empty) begin
					stat_d = deq_pkg::STAT_EMPTY;
				end else begin
					rd_en   = 1'b1;
					hit_d   = 1'b1;
					rd_addr = head_q;
					head_d  = step_up(head_q);
					count_d = count_q - CW'(1);
				end
			end
			deq_pkg::REQ_READ_POS: begin
				if (is_empty) begin
					stat_d = deq_pkg::STAT_EMPTY;
				end else if (!in_range) begin
					stat_d = deq_pkg::STAT_RANGE;
				end else begin
					rd_en   = 1'b1;
					hit_d   = 1'b1;
					rd_addr = pos_addr;
				end
			end
			default: begin
				// unused codes leave everything as is
			end
		endcase
	end

	// Update pointers and remember the pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			pend_stat_q <= deq_pkg::STAT_OK;
			pend_hit_q  <= 1'b0;
		end else if (cmd.exec) begin
			head_q      <= head_d;
			tail_q      <= tail_d;
			count_q     <= count_d;
			pend_stat_q <= stat_d;
			pend_hit_q  <= hit_d;
		end
	end

	// Word store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_w  = VW'(rd_data_q);
	assign cnt_l = LW'(count_q);

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_value_q <= pend_hit_q ? rd_w[deq_pkg::VALUE_W-1:0] : '0;
			out_stat_q  <= pend_stat_q;
			out_len_q   <= cnt_l[deq_pkg::LEN_W-1:0];
		end
	end

	// Output valid: set on load, drop when the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_valid = out_valid_q;
	assign out_valid      = out_valid_q;
	assign read_value     = out_value_q;
	assign status         = out_stat_q;
	assign length         = out_len_q;

endmodule

`default_nettype wire

// ----- sv/double_ended_queue_core.sv -----
// Channel  Dir  Width           Contents
// s_*      in   tdata 40, tuser 3  push value and read position; request code
// m_*      out  tdata 40, tuser 2  popped/read word and length; status code
//
// For each request the accept state updates pointers and issues the store access,
// then the response state loads the result once the store's registered read data
// is back. Reset clears the pointers, the count and the output valid; the store
// holds no reset. A result held in the output register stalls the block only while
// it waits and a second result is ready to replace it.
// Top level of the double-ended queue core; depends on deq_pkg, deq_ctrl, deq_dp.
`default_nettype none

module double_ended_queue_core #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// push_value [31:0], position [36:32], zero pad [39:37]
	input  wire logic [deq_pkg::IN_TDATA_W-1:0]    s_tdata,
	// req_type [2:0]
	input  wire logic [deq_pkg::REQ_W-1:0]         s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// read_value [31:0], length [36:32], zero pad [39:37]
	output logic [deq_pkg::OUT_TDATA_W-1:0]        m_tdata,
	// status [1:0]
	output logic [deq_pkg::STAT_W-1:0]             m_tuser
);

	deq_pkg::deq_cmd_t  cmd;
	deq_pkg::deq_stat_t stat;

	logic [deq_pkg::VALUE_W-1:0] read_value;
	logic [deq_pkg::LEN_W-1:0]   length;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	deq_dp #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (s_tuser),
		.push_value (s_tdata[31:0]),
		.position   (s_tdata[36:32]),
		.m_tready   (m_tready),
		.read_value (read_value),
		.status     (m_tuser),
		.length     (length),
		.out_valid  (m_tvalid)
	);

	// Pack the result word
	assign m_tdata = {3'b000, length, read_value};

endmodule

`default_nettype wire
